// ===== rtl/core/tx_ring_fifo_packetizer_top_macros.svh =====
// Assertion macros shared by the transmit ring packetizer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef TX_RING_FIFO_PACKETIZER_TOP_MACROS_SVH
`define TX_RING_FIFO_PACKETIZER_TOP_MACROS_SVH

// same-cycle implication
`define TRFP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/trfp_pkg.sv =====
// Types and constants for the transmit ring packetizer.
// No dependencies; used by the interfaces and every module but trfp_ram.
package trfp_pkg;

    localparam int DATA_W   = 8;
    localparam int WCOUNT_W = 16;
    localparam int BLK_W    = 32;
    localparam int FILL_W   = 10;
    localparam int KIND_W   = 2;
    localparam int OP_W     = 2;

    localparam logic [WCOUNT_W-1:0] RUN_MAX = 16'hFFFF;

    // request classes handed from front to back
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND  = 2'd1;
    localparam logic [OP_W-1:0] OP_BLOCK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PACKET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data_byte;
        logic              write_last;
    } cmd_t;

endpackage

// ===== rtl/core/trfp_in_if.sv =====
// Request channel: valid/ready handshake plus request fields.
// Depends on trfp_pkg.
interface trfp_in_if;
    import trfp_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] data_byte;
    logic              write_last;
    logic              host_ready;

    modport source (output valid, output req_type, output data_byte,
                    output write_last, output host_ready, input ready);
    modport sink   (input valid, input req_type, input data_byte,
                    input write_last, input host_ready, output ready);
endinterface

// ===== rtl/core/trfp_out_if.sv =====
// Result channel: valid/ready handshake plus result fields.
// Depends on trfp_pkg.
interface trfp_out_if;
    import trfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic                byte_accepted;
    logic [WCOUNT_W-1:0] write_count;
    logic [DATA_W-1:0]   tx_byte;
    logic                packet_last;
    logic [BLK_W-1:0]    blocked_total;
    logic [FILL_W-1:0]   fill_level;

    modport source (output valid, output result_kind, output byte_accepted,
                    output write_count, output tx_byte, output packet_last,
                    output blocked_total, output fill_level, input ready);
    modport sink   (input valid, input result_kind, input byte_accepted,
                    input write_count, input tx_byte, input packet_last,
                    input blocked_total, input fill_level, output ready);
endinterface

// ===== rtl/core/trfp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module trfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/trfp_front.sv =====
// Front end: takes requests, classifies them and queues them (two deep).
// Depends on trfp_pkg, trfp_in_if and the assertion macros header.
`include "tx_ring_fifo_packetizer_top_macros.svh"

module trfp_front (
    input  logic          clk,
    input  logic          rst_n,
    trfp_in_if.sink       item,
    output logic          cmd_valid,
    output trfp_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import trfp_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       new_cmd;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (count_reg != 2'd0);
    assign cmd        = q_reg[rd_idx_reg];

    always_comb
    begin
        new_cmd.data_byte  = item.data_byte;
        new_cmd.write_last = item.write_last;
        if (!item.req_type)
        begin
            new_cmd.op = OP_WRITE;
        end
        else if (item.host_ready)
        begin
            new_cmd.op = OP_SEND;
        end
        else
        begin
            new_cmd.op = OP_BLOCK;
        end
    end

    always_comb
    begin
        wr_idx_next = push ? !wr_idx_reg : wr_idx_reg;
        rd_idx_next = cmd_pop ? !rd_idx_reg : rd_idx_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_idx_reg] <= new_cmd;
        end
    end

    `TRFP_ASSERT_IMPLIES(a_q_bound, clk, rst_n, 1'b1, count_reg <= 2'd2, "queue overfilled")
    `TRFP_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, cmd_pop, count_reg != 2'd0, "pop on empty queue")
    `TRFP_ASSERT_NEXT(a_block_class, clk, rst_n, push && item.req_type && !item.host_ready && count_reg == 2'd0, cmd.op == OP_BLOCK, "busy drain not classed as blocked")
endmodule

// ===== rtl/core/trfp_back.sv =====
// Back end: owns the ring, pointers and counters; executes queued requests
// and drives the registered result channel. Depends on trfp_pkg,
// trfp_out_if, trfp_ram and the assertion macros header.
`include "tx_ring_fifo_packetizer_top_macros.svh"

module trfp_back #(
    parameter int TX_DEPTH   = 1024,
    parameter int PACKET_MAX = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  trfp_pkg::cmd_t cmd,
    output logic           cmd_pop,
    trfp_out_if.source     result
);
    import trfp_pkg::*;

    localparam int PTR_W = $clog2(TX_DEPTH);
    localparam int CNT_W = $clog2(PACKET_MAX + 1);
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg, state_next;
    logic [PTR_W-1:0]    insert_ptr_reg, insert_ptr_next;
    logic [PTR_W-1:0]    extract_ptr_reg, extract_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [WCOUNT_W-1:0] run_count_reg, run_count_next;
    logic [BLK_W-1:0]    blocked_reg, blocked_next;
    logic [CNT_W-1:0]    issue_left_reg, issue_left_next;
    logic [CNT_W-1:0]    out_left_reg, out_left_next;
    logic                pend_reg, pend_next;
    logic [FILL_W-1:0]   pkt_fill_reg, pkt_fill_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                acc_reg, acc_next;
    logic [WCOUNT_W-1:0] wcnt_reg, wcnt_next;
    logic [DATA_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    logic                out_free;
    logic [PTR_W-1:0]    fill_now;
    logic [PTR_W-1:0]    insert_inc;
    logic                full;
    logic [CMP_W-1:0]    fill_wide;
    logic [CMP_W-1:0]    chunk_wide;
    logic [PTR_W-1:0]    chunk_ptr;
    logic [WCOUNT_W-1:0] run_after;
    logic                move;
    logic                issue;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_rdata;

    function automatic logic [FILL_W-1:0] fill_field(input logic [PTR_W-1:0] v);
        logic [PTR_W+FILL_W-1:0] e;
        e = (PTR_W+FILL_W)'(v);
        return e[FILL_W-1:0];
    endfunction

    assign out_free   = !out_valid_reg || result.ready;
    assign fill_now   = insert_ptr_reg - extract_ptr_reg;
    assign insert_inc = insert_ptr_reg + 1'b1;
    assign full       = (insert_inc == extract_ptr_reg);
    assign fill_wide  = CMP_W'(fill_now);
    assign chunk_wide = (fill_wide < CMP_W'(PACKET_MAX)) ? fill_wide : CMP_W'(PACKET_MAX);
    assign chunk_ptr  = chunk_wide[PTR_W-1:0];
    assign run_after  = (!full && run_count_reg != RUN_MAX) ? run_count_reg + 16'd1
                                                            : run_count_reg;

    // one byte in flight from the RAM; hold its output while the slot is stalled
    assign move  = (state_reg == ST_DRAIN) && pend_reg && out_free;
    assign issue = (state_reg == ST_DRAIN) && (issue_left_reg != '0) && (!pend_reg || move);

    always_comb
    begin
        state_next       = state_reg;
        insert_ptr_next  = insert_ptr_reg;
        extract_ptr_next = extract_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        run_count_next   = run_count_reg;
        blocked_next     = blocked_reg;
        issue_left_next  = issue_left_reg;
        out_left_next    = out_left_reg;
        pend_next        = pend_reg;
        pkt_fill_next    = pkt_fill_reg;
        cmd_pop          = 1'b0;
        ram_we           = 1'b0;

        out_valid_next = out_valid_reg && !result.ready;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        wcnt_next      = wcnt_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        blk_next       = blk_reg;
        fill_next      = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                ram_we         = !full;
                                insert_ptr_next = full ? insert_ptr_reg : insert_inc;
                                run_count_next = cmd.write_last ? '0 : run_after;
                                out_valid_next = 1'b1;
                                kind_next      = KIND_WRITE;
                                acc_next       = !full;
                                wcnt_next      = run_after;
                                byte_next      = '0;
                                last_next      = 1'b0;
                                blk_next       = '0;
                                fill_next      = fill_field(full ? fill_now
                                                                 : fill_now + 1'b1);
                            end
                        end
                        OP_BLOCK:
                        begin
                            if (fill_now == '0)
                            begin
                                cmd_pop = 1'b1;
                            end
                            else if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                blocked_next   = blocked_reg + 32'd1;
                                out_valid_next = 1'b1;
                                kind_next      = KIND_BLOCKED;
                                acc_next       = 1'b0;
                                wcnt_next      = '0;
                                byte_next      = '0;
                                last_next      = 1'b0;
                                blk_next       = blocked_reg + 32'd1;
                                fill_next      = fill_field(fill_now);
                            end
                        end
                        OP_SEND:
                        begin
                            cmd_pop = 1'b1;
                            if (fill_now != '0)
                            begin
                                state_next       = ST_DRAIN;
                                rd_ptr_next      = extract_ptr_reg;
                                extract_ptr_next = extract_ptr_reg + chunk_ptr;
                                issue_left_next  = chunk_wide[CNT_W-1:0];
                                out_left_next    = chunk_wide[CNT_W-1:0];
                                pkt_fill_next    = fill_field(fill_now - chunk_ptr);
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (issue)
                begin
                    rd_ptr_next     = rd_ptr_reg + 1'b1;
                    issue_left_next = issue_left_reg - 1'b1;
                    pend_next       = 1'b1;
                end
                else if (move)
                begin
                    pend_next = 1'b0;
                end
                if (move)
                begin
                    out_left_next  = out_left_reg - 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PACKET;
                    acc_next       = 1'b0;
                    wcnt_next      = '0;
                    byte_next      = ram_rdata;
                    last_next      = (out_left_reg == CNT_W'(1));
                    blk_next       = '0;
                    fill_next      = pkt_fill_reg;
                    if (out_left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            insert_ptr_reg  <= '0;
            extract_ptr_reg <= '0;
            rd_ptr_reg      <= '0;
            run_count_reg   <= '0;
            blocked_reg     <= '0;
            issue_left_reg  <= '0;
            out_left_reg    <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            insert_ptr_reg  <= insert_ptr_next;
            extract_ptr_reg <= extract_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            run_count_reg   <= run_count_next;
            blocked_reg     <= blocked_next;
            issue_left_reg  <= issue_left_next;
            out_left_reg    <= out_left_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_fill_reg <= pkt_fill_next;
        kind_reg     <= kind_next;
        acc_reg      <= acc_next;
        wcnt_reg     <= wcnt_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        blk_reg      <= blk_next;
        fill_reg     <= fill_next;
    end

    trfp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TX_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (insert_ptr_reg),
        .wdata (cmd.data_byte),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = kind_reg;
    assign result.byte_accepted = acc_reg;
    assign result.write_count   = wcnt_reg;
    assign result.tx_byte       = byte_reg;
    assign result.packet_last   = last_reg;
    assign result.blocked_total = blk_reg;
    assign result.fill_level    = fill_reg;

    `TRFP_ASSERT_IMPLIES(a_drain_left, clk, rst_n, state_reg == ST_DRAIN, out_left_reg != '0 && issue_left_reg <= out_left_reg, "drain counters out of step")
    `TRFP_ASSERT_IMPLIES(a_no_pop_drain, clk, rst_n, state_reg == ST_DRAIN, !cmd_pop, "request popped during drain")
    `TRFP_ASSERT_IMPLIES(a_last_kind, clk, rst_n, result.valid && result.packet_last, result.result_kind == KIND_PACKET, "last flag on non-packet result")
    `TRFP_ASSERT_NEXT(a_write_ptr, clk, rst_n, ram_we, insert_ptr_reg == $past(insert_inc), "insert pointer not advanced")
endmodule

// ===== rtl/core/tx_ring_fifo_packetizer_top.sv =====
// Transmit ring packetizer top level: front end, request queue, back end.
// Depends on trfp_pkg, trfp_in_if, trfp_out_if, trfp_front and trfp_back.
//
// Byte ring of TX_DEPTH entries (power of two, one slot kept free) drained
// as packets of up to PACKET_MAX bytes. Requests enter a two-deep queue, so
// the request side can run two requests ahead while the result register is
// stalled. A write or a blocked drain yields one result; a drain on an empty
// ring yields nothing. A drain of n bytes takes the request, then streams
// one byte per cycle through the registered RAM read while the result side
// does not stall; it holds the back end, which takes no other request, until
// its last byte is out. No clearing pass: only bytes written are ever read.
module tx_ring_fifo_packetizer_top #(
    parameter int TX_DEPTH   = 1024,
    parameter int PACKET_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    trfp_in_if.sink   item,
    trfp_out_if.source result
);
    import trfp_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    trfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    trfp_back #(
        .TX_DEPTH   (TX_DEPTH),
        .PACKET_MAX (PACKET_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );
endmodule

// ===== dv/trfp_ring_checker.sv =====
// Checker for the transmit ring packetizer: keeps a mirror of the byte ring,
// works out the results of every accepted request and compares them in order.
// Depends on trfp_pkg, trfp_in_if and trfp_out_if.
module trfp_ring_checker
    import trfp_pkg::*;
#(
    parameter int TX_DEPTH   = 1024,
    parameter int PACKET_MAX = 64
) (
    input  logic clk,
    input  logic rst_n,
    trfp_in_if   req_mon,
    trfp_out_if  res_mon,
    output int   fail_count,
    output int   outstanding
);

    localparam int   PTR_W      = $clog2(TX_DEPTH);
    localparam int   PRINT_MAX  = 100;
    localparam logic REQ_WRITE  = 1'(OP_WRITE);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                accepted;
        logic [WCOUNT_W-1:0] count;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic [BLK_W-1:0]    blocked;
        logic [FILL_W-1:0]   fill;
    } tx_result_t;

    logic [DATA_W-1:0]   ring_mem [TX_DEPTH];
    logic [PTR_W-1:0]    wr_ptr      = '0;
    logic [PTR_W-1:0]    rd_ptr      = '0;
    logic [BLK_W-1:0]    blocked_cnt = '0;
    logic [WCOUNT_W-1:0] run_len     = '0;
    tx_result_t          results_due[$];
    int                  results_seen = 0;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_failure(input string msg);
        if (fail_count < PRINT_MAX)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [BLK_W-1:0] want,
                                 input logic [BLK_W-1:0] got);
        if (want !== got)
            report_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    // Mirror of the ring for one accepted request; queues every result it causes.
    task automatic predict_ring_step(input logic rtype, input logic [DATA_W-1:0] wdata,
                                     input logic wlast, input logic host_rdy);
        tx_result_t       r;
        logic [PTR_W-1:0] queued;
        int               chunk;
        r = '0;
        queued = wr_ptr - rd_ptr;
        if (rtype == REQ_WRITE)
        begin
            r.kind = KIND_WRITE;
            // one slot kept free: full when the write pointer sits just behind the read pointer
            if (wr_ptr != PTR_W'(rd_ptr - 1))
            begin
                ring_mem[wr_ptr] = wdata;
                wr_ptr = wr_ptr + 1'b1;
                r.accepted = 1'b1;
                if (run_len != RUN_MAX)
                    run_len = run_len + 1'b1;
            end
            r.count = run_len;
            r.fill = FILL_W'(PTR_W'(wr_ptr - rd_ptr));
            // the call ends here even if the byte was dropped
            if (wlast)
                run_len = '0;
            results_due.push_back(r);
        end
        else if (queued != 0)
        begin
            if (!host_rdy)
            begin
                blocked_cnt = blocked_cnt + 1'b1;
                r.kind = KIND_BLOCKED;
                r.blocked = blocked_cnt;
                r.fill = FILL_W'(queued);
                results_due.push_back(r);
            end
            else
            begin
                chunk = (int'(queued) < PACKET_MAX) ? int'(queued) : PACKET_MAX;
                for (int i = 0; i < chunk; i++)
                begin
                    r = '0;
                    r.kind = KIND_PACKET;
                    r.data = ring_mem[PTR_W'(rd_ptr + i)];
                    r.last = (i == chunk - 1);
                    r.fill = FILL_W'(int'(queued) - chunk);
                    results_due.push_back(r);
                end
                rd_ptr = PTR_W'(rd_ptr + chunk);
            end
        end
    endtask

    always @(posedge clk)
    begin : watch
        tx_result_t want;
        if (rst_n)
        begin
            if (req_mon.valid && req_mon.ready)
                predict_ring_step(req_mon.req_type, req_mon.data_byte,
                                  req_mon.write_last, req_mon.host_ready);
            if (res_mon.valid && res_mon.ready)
            begin
                if (results_due.size() == 0)
                    report_failure($sformatf("unexpected result of kind %0d",
                                             res_mon.result_kind));
                else
                begin
                    want = results_due.pop_front();
                    compare_field("result_kind", want.kind, res_mon.result_kind);
                    compare_field("byte_accepted", want.accepted, res_mon.byte_accepted);
                    compare_field("write_count", want.count, res_mon.write_count);
                    compare_field("tx_byte", want.data, res_mon.tx_byte);
                    compare_field("packet_last", want.last, res_mon.packet_last);
                    compare_field("blocked_total", want.blocked, res_mon.blocked_total);
                    compare_field("fill_level", want.fill, res_mon.fill_level);
                end
                results_seen++;
            end
            outstanding <= results_due.size();
        end
    end

endmodule

// ===== dv/tx_ring_fifo_packetizer_top_test.sv =====
// Testbench top for the transmit ring packetizer: clock, reset, request
// stimulus with random pacing on both channels, watchdog and verdict.
// Depends on trfp_pkg, trfp_in_if, trfp_out_if, trfp_ring_checker and the RTL.
module tx_ring_fifo_packetizer_top_test;
    import trfp_pkg::*;

    localparam int   RING_DEPTH  = 1024;
    localparam int   PKT_MAX     = 64;
    localparam int   IDLE_LIMIT  = 3000;
    localparam int   TAIL_CYCLES = 100;
    localparam int   LONG_CALL   = 150;
    localparam logic REQ_WRITE   = 1'(OP_WRITE);
    localparam logic REQ_DRAIN   = 1'(OP_SEND);

    logic clk = 1'b0;
    logic rst_n;
    logic src_quiet;
    logic sink_quiet;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   outstanding;

    trfp_in_if  req_ch ();
    trfp_out_if res_ch ();

    tx_ring_fifo_packetizer_top #(
        .TX_DEPTH   (RING_DEPTH),
        .PACKET_MAX (PKT_MAX)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch)
    );

    trfp_ring_checker #(
        .TX_DEPTH   (RING_DEPTH),
        .PACKET_MAX (PKT_MAX)
    ) u_ring_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .res_mon     (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: after each accepted result, hold ready low for a random stretch
    always @(posedge clk)
    begin : sink_pacing
        int stall;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            stall = sink_quiet ? 0 : $urandom_range(0, 9);
            res_ch.ready <= (stall == 0);
            stall_left <= stall;
        end
        else if (!res_ch.ready)
        begin
            if (stall_left <= 1)
            begin
                res_ch.ready <= 1'b1;
                stall_left <= 0;
            end
            else
                stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tx_ring_fifo_packetizer_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_req(input logic rtype, input logic [DATA_W-1:0] wdata,
                            input logic wlast, input logic host_rdy);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rtype;
        req_ch.data_byte  <= wdata;
        req_ch.write_last <= wlast;
        req_ch.host_ready <= host_rdy;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly complete write calls and drains; a few calls with a wrong last
    // flag and a few fully random requests as noise.
    task automatic run_mixed(input int n_items, input int drain_weight);
        int   sent;
        int   pick;
        int   call_len;
        logic wlast;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < drain_weight)
            begin
                send_req(REQ_DRAIN, 8'($urandom), 1'($urandom),
                         1'($urandom_range(0, 3) != 0));
                sent++;
            end
            else if (pick == 9)
            begin
                send_req(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                call_len = $urandom_range(1, 12);
                for (int j = 0; j < call_len; j++)
                begin
                    wlast = (j == call_len - 1);
                    if ($urandom_range(0, 15) == 0)
                        wlast = !wlast;
                    send_req(REQ_WRITE, 8'($urandom), wlast, 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_WRITE;
        req_ch.data_byte = '0;
        req_ch.write_last = 1'b0;
        req_ch.host_ready = 1'b0;
        res_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // drains on an empty ring give nothing, ready or not
        send_req(REQ_DRAIN, 8'hFF, 1'b1, 1'b1);
        send_req(REQ_DRAIN, 8'h00, 1'b0, 1'b0);
        send_req(REQ_WRITE, 8'h00, 1'b0, 1'b1);
        send_req(REQ_WRITE, 8'hFF, 1'b0, 1'b0);
        send_req(REQ_WRITE, 8'hA5, 1'b1, 1'b1);
        send_req(REQ_DRAIN, 8'h00, 1'b0, 1'b0);
        send_req(REQ_DRAIN, 8'hFF, 1'b1, 1'b0);
        send_req(REQ_DRAIN, 8'h3C, 1'b1, 1'b1);
        send_req(REQ_DRAIN, 8'h00, 1'b0, 1'b1);
        send_req(REQ_WRITE, 8'h5A, 1'b1, 1'b0);
        send_req(REQ_WRITE, 8'h0F, 1'b0, 1'b1);
        send_req(REQ_WRITE, 8'hF0, 1'b1, 1'b0);
        send_req(REQ_DRAIN, 8'h00, 1'b0, 1'b0);
        send_req(REQ_DRAIN, 8'h00, 1'b0, 1'b1);
        wait_results_drained();

        run_mixed(120, 3);
        wait_results_drained();

        // one long call back to back, then several full-size packets,
        // some drains with the host busy
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        for (int i = 0; i < LONG_CALL; i++)
            send_req(REQ_WRITE, 8'($urandom), (i == LONG_CALL - 1), 1'($urandom));
        for (int i = 0; i < 8; i++)
            send_req(REQ_DRAIN, 8'($urandom), 1'($urandom), (i % 3 != 1));

        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        run_mixed(80, 1);
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        run_mixed(40, 2);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tx_ring_fifo_packetizer_top test passed");
        else
            $display("tx_ring_fifo_packetizer_top test failed");
        $finish;
    end

endmodule
